FILE: hdl/vrba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrba_pkg
// Shared types and constants for the virtual region bump allocator.
// ----------------------------------------------------------------------------
package vrba_pkg;

   localparam int MAX_REGIONS_DEF = 32;
   localparam int PAGE_BYTES      = 4096;
   localparam int PAGE_SHIFT      = $clog2(PAGE_BYTES);

   localparam int ADDR_W     = 32;
   localparam int ALU_W      = 34;
   localparam int PAGE_CNT_W = 21;
   localparam logic [PAGE_CNT_W-1:0] PAGE_CNT_MAX = '1;

   localparam logic [ALU_W-1:0] PAGE_STEP = ALU_W'(PAGE_BYTES);
   localparam logic [ALU_W-1:0] PAGE_MASK = ALU_W'(PAGE_BYTES - 1);

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_CHECK   = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_RANGE    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic CSR_POOL_BASE  = 1'b0;
   localparam logic CSR_POOL_BYTES = 1'b1;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } alu_req_type;

endpackage
`default_nettype wire

FILE: hdl/vrba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrba_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vrba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

FILE: hdl/vrba_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrba_alu
// Shared add/subtract unit. Bit ALU_W of the result is the borrow on subtract.
// ----------------------------------------------------------------------------
module vrba_alu (
   input  wire vrba_pkg::alu_req_type           req,
   output logic [vrba_pkg::ALU_W:0]             sum
);

   logic [vrba_pkg::ALU_W:0] a_ext;
   logic [vrba_pkg::ALU_W:0] b_ext;

   always_comb begin
      a_ext = {1'b0, req.a};
      b_ext = req.sub ? ~{1'b0, req.b} : {1'b0, req.b};
      sum   = a_ext + b_ext + {{vrba_pkg::ALU_W{1'b0}}, req.sub};
   end

endmodule
`default_nettype wire

FILE: hdl/vrba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrba_ctrl
// Request sequencer: drives the shared ALU, scans the region RAM and holds
// the result register.
// ----------------------------------------------------------------------------
module vrba_ctrl #(
   parameter int MAX_REGIONS = vrba_pkg::MAX_REGIONS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [31:0]                           pool_base,
   input  wire logic [31:0]                           pool_bytes,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [1:0]                            req_opcode,
   input  wire logic [31:0]                           req_bytes,
   input  wire logic [31:0]                           req_address,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [1:0]                                 rsp_status,
   output logic [31:0]                                rsp_start,
   output logic [vrba_pkg::PAGE_CNT_W-1:0]            rsp_pages,
   output logic                                       rsp_inside,
   output vrba_pkg::alu_req_type                      alu_req,
   input  wire logic [vrba_pkg::ALU_W:0]              alu_sum,
   output logic                                       ram_wr_en,
   output logic [(MAX_REGIONS > 1 ? $clog2(MAX_REGIONS) : 1)-1:0] ram_wr_addr,
   output logic [63:0]                                ram_wr_data,
   output logic [(MAX_REGIONS > 1 ? $clog2(MAX_REGIONS) : 1)-1:0] ram_rd_addr,
   input  wire logic [63:0]                           ram_rd_data
);

   localparam int IDX_W = MAX_REGIONS > 1 ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W = $clog2(MAX_REGIONS + 1);
   localparam int AW    = vrba_pkg::ALU_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RND,
      S_FIRST,
      S_LAST,
      S_LIMIT,
      S_CMP_LIM,
      S_CMP_BASE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_REL_SUB,
      S_EMIT
   } state_type;

   state_type                       state_ff;
   logic [1:0]                      op_ff;
   logic [31:0]                     bytes_ff;
   logic [31:0]                     addr_ff;
   logic [AW-1:0]                   tmp_ff;
   logic [AW-1:0]                   first_ff;
   logic [AW-1:0]                   x_ff;
   logic                            lt_lim_ff;
   logic [IDX_W-1:0]                idx_ff;
   logic [CNT_W-1:0]                count_ff;
   logic [31:0]                     last_end_ff;
   logic [1:0]                      res_status_ff;
   logic [31:0]                     res_start_ff;
   logic [vrba_pkg::PAGE_CNT_W-1:0] res_pages_ff;
   logic                            res_inside_ff;
   logic                            rsp_valid_ff;
   logic [1:0]                      rsp_status_ff;
   logic [31:0]                     rsp_start_ff;
   logic [vrba_pkg::PAGE_CNT_W-1:0] rsp_pages_ff;
   logic                            rsp_inside_ff;

   logic                            in_range;
   logic [31:0]                     pages_wide;

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_start  = rsp_start_ff;
   assign rsp_pages  = rsp_pages_ff;
   assign rsp_inside = rsp_inside_ff;

   assign in_range   = lt_lim_ff && !alu_sum[AW] && (x_ff[AW-1:32] == '0);
   assign pages_wide = alu_sum[31:0] >> vrba_pkg::PAGE_SHIFT;

   assign ram_wr_en   = (state_ff == S_CMP_BASE) && (op_ff == vrba_pkg::OP_ALLOC) && in_range;
   assign ram_wr_addr = count_ff[IDX_W-1:0];
   assign ram_wr_data = {x_ff[31:0], first_ff[31:0]};
   assign ram_rd_addr = idx_ff;

   always_comb begin
      alu_req = '0;
      unique case (state_ff)
         S_RND: begin
            alu_req.a = {2'b00, bytes_ff};
            alu_req.b = vrba_pkg::PAGE_MASK;
         end
         S_FIRST: begin
            alu_req.a = {2'b00, pool_base};
            alu_req.b = vrba_pkg::PAGE_STEP;
         end
         S_LAST: begin
            alu_req.a = first_ff;
            alu_req.b = tmp_ff;
         end
         S_LIMIT: begin
            alu_req.a = {2'b00, pool_base};
            alu_req.b = {2'b00, pool_bytes};
         end
         S_CMP_LIM: begin
            alu_req.a   = x_ff;
            alu_req.b   = tmp_ff;
            alu_req.sub = 1'b1;
         end
         S_CMP_BASE: begin
            alu_req.a   = x_ff;
            alu_req.b   = {2'b00, pool_base};
            alu_req.sub = 1'b1;
         end
         S_REL_SUB: begin
            alu_req.a   = x_ff;
            alu_req.b   = first_ff;
            alu_req.sub = 1'b1;
         end
         default: alu_req = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff         <= req_opcode;
                  bytes_ff      <= req_bytes;
                  addr_ff       <= req_address;
                  x_ff          <= {2'b00, req_address};
                  idx_ff        <= '0;
                  res_status_ff <= vrba_pkg::ST_OK;
                  res_start_ff  <= '0;
                  res_pages_ff  <= '0;
                  res_inside_ff <= 1'b0;
                  unique case (req_opcode)
                     vrba_pkg::OP_ALLOC: begin
                        if (count_ff == CNT_W'(MAX_REGIONS)) begin
                           res_status_ff <= vrba_pkg::ST_FULL;
                           state_ff      <= S_EMIT;
                        end else begin
                           state_ff <= S_RND;
                        end
                     end
                     vrba_pkg::OP_RELEASE: begin
                        if (count_ff == '0) begin
                           res_status_ff <= vrba_pkg::ST_NOTFOUND;
                           state_ff      <= S_EMIT;
                        end else begin
                           state_ff <= S_SCAN_RD;
                        end
                     end
                     vrba_pkg::OP_CHECK: state_ff <= S_LIMIT;
                     default:            state_ff <= S_EMIT;
                  endcase
               end
            end
            S_RND: begin
               tmp_ff   <= alu_sum[AW-1:0] & ~vrba_pkg::PAGE_MASK;
               state_ff <= S_FIRST;
            end
            S_FIRST: begin
               first_ff <= (count_ff == '0) ? alu_sum[AW-1:0] : {2'b00, last_end_ff};
               state_ff <= S_LAST;
            end
            S_LAST: begin
               x_ff     <= alu_sum[AW-1:0];
               state_ff <= S_LIMIT;
            end
            S_LIMIT: begin
               tmp_ff   <= alu_sum[AW-1:0];
               state_ff <= S_CMP_LIM;
            end
            S_CMP_LIM: begin
               lt_lim_ff <= alu_sum[AW];
               state_ff  <= S_CMP_BASE;
            end
            S_CMP_BASE: begin
               if (op_ff == vrba_pkg::OP_CHECK) begin
                  res_inside_ff <= in_range;
               end else if (in_range) begin
                  count_ff     <= count_ff + 1'b1;
                  last_end_ff  <= x_ff[31:0];
                  res_start_ff <= first_ff[31:0];
               end else begin
                  res_status_ff <= vrba_pkg::ST_RANGE;
               end
               state_ff <= S_EMIT;
            end
            S_SCAN_RD: state_ff <= S_SCAN_CMP;
            S_SCAN_CMP: begin
               if (ram_rd_data[31:0] == addr_ff) begin
                  first_ff <= {2'b00, ram_rd_data[31:0]};
                  x_ff     <= {2'b00, ram_rd_data[63:32]};
                  state_ff <= S_REL_SUB;
               end else if ((CNT_W'(idx_ff) + 1'b1) == count_ff) begin
                  res_status_ff <= vrba_pkg::ST_NOTFOUND;
                  state_ff      <= S_EMIT;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_SCAN_RD;
               end
            end
            S_REL_SUB: begin
               res_start_ff <= first_ff[31:0];
               res_pages_ff <= (pages_wide > 32'(vrba_pkg::PAGE_CNT_MAX)) ?
                               vrba_pkg::PAGE_CNT_MAX :
                               pages_wide[vrba_pkg::PAGE_CNT_W-1:0];
               state_ff     <= S_EMIT;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_start_ff  <= res_start_ff;
                  rsp_pages_ff  <= res_pages_ff;
                  rsp_inside_ff <= res_inside_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: hdl/virtual_region_bump_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// virtual_region_bump_allocator
// Bump allocator over one virtual address pool with a region table.
//
//   channel  dir  fields
//   req_     in   tuser: opcode; tdata: request_bytes, query_address
//   rsp_     out  tdata: status, region_start, page_count, inside_pool
//   csr_     in   index 0 pool_base, index 1 pool_bytes
//
// Allocate: round, first, last, limit, compare limit and base, emit. Check: from
// limit. Release: scan, subtract on a match. Full table, empty release, unused
// opcode: emit. One request in flight; req_tready is high only while the sequencer idles.
// A finished result sits in the output register while the next request runs;
// the next result waits in the last step until that one is taken.
// Synchronous reset empties the region table by clearing its count.
// ----------------------------------------------------------------------------
module virtual_region_bump_allocator #(
   parameter int MAX_REGIONS = vrba_pkg::MAX_REGIONS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // request_bytes[31:0], query_address[63:32]
   input  wire logic [1:0]  req_tuser,   // opcode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // status[1:0], region_start[33:2],
                                         // page_count[54:34], inside_pool[55]
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int IDX_W = MAX_REGIONS > 1 ? $clog2(MAX_REGIONS) : 1;

   logic [31:0]                     pool_base_ff;
   logic [31:0]                     pool_bytes_ff;
   vrba_pkg::alu_req_type           alu_req;
   logic [vrba_pkg::ALU_W:0]        alu_sum;
   logic                            ram_wr_en;
   logic [IDX_W-1:0]                ram_wr_addr;
   logic [63:0]                     ram_wr_data;
   logic [IDX_W-1:0]                ram_rd_addr;
   logic [63:0]                     ram_rd_data;
   logic [1:0]                      rsp_status;
   logic [31:0]                     rsp_start;
   logic [vrba_pkg::PAGE_CNT_W-1:0] rsp_pages;
   logic                            rsp_inside;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff  <= '0;
         pool_bytes_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            vrba_pkg::CSR_POOL_BASE:  pool_base_ff  <= csr_wdata;
            vrba_pkg::CSR_POOL_BYTES: pool_bytes_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_tdata = {rsp_inside, rsp_pages, rsp_start, rsp_status};

   vrba_alu u_alu (
      .req (alu_req),
      .sum (alu_sum)
   );

   vrba_ram #(
      .WIDTH (64),
      .DEPTH (MAX_REGIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   vrba_ctrl #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .pool_base   (pool_base_ff),
      .pool_bytes  (pool_bytes_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_opcode  (req_tuser),
      .req_bytes   (req_tdata[31:0]),
      .req_address (req_tdata[63:32]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (rsp_status),
      .rsp_start   (rsp_start),
      .rsp_pages   (rsp_pages),
      .rsp_inside  (rsp_inside),
      .alu_req     (alu_req),
      .alu_sum     (alu_sum),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

endmodule
`default_nettype wire

FILE: hdl/vrba_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrba_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module vrba_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   // one request at a time
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after a transfer");

   // only a successful release reports pages
   a_pages_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[54:34] != '0) |->
         (rsp_tdata[1:0] == vrba_pkg::ST_OK) && !rsp_tdata[55])
      else $error("page_count on a non-release result");

   // a check result carries no region
   a_inside_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[55] |->
         (rsp_tdata[33:2] == '0) && (rsp_tdata[1:0] == vrba_pkg::ST_OK))
      else $error("inside_pool with region data");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

endmodule

bind virtual_region_bump_allocator vrba_checker u_vrba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

FILE: dv/tb_virtual_region_bump_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_virtual_region_bump_allocator
// Self-checking bench for the region bump allocator. A driver sends allocate,
// release, check and unused requests from a queue. A monitor compares every
// response field against an in-bench model of the pool and region table. The
// pool is moved through several base and size settings, extremes included.
// ----------------------------------------------------------------------------
module tb_virtual_region_bump_allocator;
   import vrba_pkg::*;

   localparam int         MAX_REGIONS   = MAX_REGIONS_DEF;
   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam int         SETTLE_CYCLES = 80;
   localparam int         STALL_LIMIT   = 20000;

   typedef struct {
      logic [1:0]  opcode;
      logic [31:0] request_bytes;
      logic [31:0] query_address;
   } pool_request_t;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] region_start;
      logic [20:0] page_count;
      logic        inside_pool;
   } pool_response_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic        csr_index  = 1'b0;
   logic [31:0] csr_wdata  = '0;

   // model state
   logic [31:0] pool_base_q  = '0;
   logic [31:0] pool_bytes_q = '0;
   logic [31:0] region_begin [MAX_REGIONS];
   logic [31:0] region_end   [MAX_REGIONS];
   int          region_count = 0;

   pool_request_t  queued_requests [$];
   pool_response_t awaited_responses [$];

   bit steady_mode = 1'b0;
   int req_gap     = 0;
   int rsp_stall   = 0;
   int idle_cycles = 0;
   int n_issued    = 0;
   int n_responses = 0;
   int mismatch_count = 0;
   int n_placed = 0, n_range = 0, n_full = 0;
   int n_freed = 0, n_missing = 0, n_checked = 0, n_inside = 0;

   virtual_region_bump_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int pick_gap();
      int sel;
      if (steady_mode) return 0;
      sel = $urandom_range(0, 99);
      if (sel < 55) return 0;
      if (sel < 85) return $urandom_range(1, 3);
      if (sel < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   // Applies one request to the model and returns the response it must give.
   function automatic pool_response_t predict_pool_response(pool_request_t r);
      pool_response_t p;
      logic [63:0]    limit, pages, first, last;
      logic [31:0]    span;
      logic           hit;
      int             i;
      p.status       = ST_OK;
      p.region_start = '0;
      p.page_count   = '0;
      p.inside_pool  = 1'b0;
      limit = 64'(pool_base_q) + 64'(pool_bytes_q);
      hit   = 1'b0;
      case (r.opcode)
         OP_ALLOC: begin
            if (region_count >= MAX_REGIONS) begin
               p.status = ST_FULL;
            end else begin
               pages = (64'(r.request_bytes) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
               first = (region_count == 0) ? 64'(pool_base_q) + 64'(PAGE_BYTES)
                                           : 64'(region_end[region_count-1]);
               last  = first + pages * 64'(PAGE_BYTES);
               if (last < limit && last >= 64'(pool_base_q) && last <= 64'hFFFF_FFFF) begin
                  region_begin[region_count] = first[31:0];
                  region_end[region_count]   = last[31:0];
                  region_count++;
                  p.region_start = first[31:0];
               end else begin
                  p.status = ST_RANGE;
               end
            end
         end
         OP_RELEASE: begin
            p.status = ST_NOTFOUND;
            for (i = 0; i < region_count; i++) begin
               if (!hit && region_begin[i] == r.query_address) begin
                  hit            = 1'b1;
                  span           = region_end[i] - region_begin[i];
                  pages          = 64'(span) / 64'(PAGE_BYTES);
                  p.status       = ST_OK;
                  p.region_start = region_begin[i];
                  p.page_count   = (pages > 64'(PAGE_CNT_MAX)) ? PAGE_CNT_MAX
                                                              : pages[20:0];
               end
            end
         end
         OP_CHECK: begin
            p.inside_pool = (64'(r.query_address) >= 64'(pool_base_q) &&
                             64'(r.query_address) < limit);
         end
         default: begin
         end
      endcase
      return p;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pool_base_q  <= '0;
         pool_bytes_q <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_POOL_BASE) pool_base_q  <= csr_wdata;
         else                            pool_bytes_q <= csr_wdata;
      end
   end

   // request driver; predicts the response at each accepted transfer
   always @(posedge clock) begin
      pool_request_t  r;
      pool_response_t p;
      if (reset) begin
         req_tvalid   <= 1'b0;
         req_gap      <= 0;
         region_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            r.opcode        = req_tuser;
            r.request_bytes = req_tdata[31:0];
            r.query_address = req_tdata[63:32];
            p = predict_pool_response(r);
            awaited_responses.push_back(p);
            case (r.opcode)
               OP_ALLOC: begin
                  if (p.status == ST_OK)         n_placed++;
                  else if (p.status == ST_RANGE) n_range++;
                  else                           n_full++;
               end
               OP_RELEASE: begin
                  if (p.status == ST_OK) n_freed++;
                  else                   n_missing++;
               end
               OP_CHECK: begin
                  n_checked++;
                  if (p.inside_pool) n_inside++;
               end
               default: begin
               end
            endcase
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap    <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (queued_requests.size() > 0) begin
               r = queued_requests.pop_front();
               req_tdata  <= {r.query_address, r.request_bytes};
               req_tuser  <= r.opcode;
               req_tvalid <= 1'b1;
               req_gap    <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
         $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, seen);
         mismatch_count++;
      end
   endtask

   // response monitor and backpressure
   always @(posedge clock) begin
      pool_response_t want;
      int             s;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_responses++;
            if (awaited_responses.size() == 0) begin
               $display("%0t ns: response with none expected, actual %h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = awaited_responses.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_tdata[1:0]));
               compare_field("region_start", want.region_start, rsp_tdata[33:2]);
               compare_field("page_count", 32'(want.page_count), 32'(rsp_tdata[54:34]));
               compare_field("inside_pool", 32'(want.inside_pool), 32'(rsp_tdata[55]));
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall  <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            s = ((rsp_tvalid && rsp_tready) || $urandom_range(0, 7) == 0) ? pick_gap() : 0;
            rsp_stall  <= s;
            rsp_tready <= (s == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_request(logic [1:0] op, logic [31:0] bytes, logic [31:0] addr);
      pool_request_t r;
      r.opcode        = op;
      r.request_bytes = bytes;
      r.query_address = addr;
      queued_requests.push_back(r);
      n_issued++;
   endtask

   task automatic wait_idle();
      while (n_responses != n_issued || queued_requests.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_pool(logic [31:0] base, logic [31:0] bytes);
      wait_idle();
      write_csr(CSR_POOL_BASE, base);
      write_csr(CSR_POOL_BYTES, bytes);
   endtask

   task automatic queue_random_phase(int count);
      pool_request_t r;
      logic [63:0]   limit, next_first;
      int            k, n, sel;
      n = 0;
      while (n < count) begin
         @(negedge clock);
         while (queued_requests.size() > 2) @(negedge clock);
         steady_mode = ($urandom_range(0, 5) == 0);
         for (k = 0; k < 16 && n < count; k++) begin
            limit      = 64'(pool_base_q) + 64'(pool_bytes_q);
            next_first = (region_count == 0) ? 64'(pool_base_q) + 64'(PAGE_BYTES)
                                             : 64'(region_end[region_count-1]);
            r.request_bytes = $urandom;
            r.query_address = $urandom;
            sel = $urandom_range(0, 99);
            if (sel < 30)      r.opcode = OP_ALLOC;
            else if (sel < 60) r.opcode = OP_RELEASE;
            else if (sel < 92) r.opcode = OP_CHECK;
            else               r.opcode = OP_UNUSED;
            sel = $urandom_range(0, 99);
            case (r.opcode)
               OP_ALLOC: begin
                  if (sel < 57) begin
                     r.request_bytes = $urandom_range(0, 4 * PAGE_BYTES);
                  end else if (sel < 75) begin
                     r.request_bytes = PAGE_BYTES * $urandom_range(0, 8);
                  end else if (sel < 83) begin
                     // land exactly on the pool limit, or one page below it
                     if (limit > next_first)
                        r.request_bytes = 32'(limit - next_first) -
                                          ($urandom_range(0, 1) ? PAGE_BYTES : 0);
                     else
                        r.request_bytes = $urandom_range(0, PAGE_BYTES);
                  end
               end
               OP_RELEASE: begin
                  if (region_count > 0 && sel < 75) begin
                     r.query_address = region_begin[$urandom_range(0, region_count - 1)];
                     if (sel >= 65) r.query_address = r.query_address + 32'd1;
                  end
               end
               OP_CHECK: begin
                  if (sel < 10)      r.query_address = pool_base_q - 32'd1;
                  else if (sel < 20) r.query_address = pool_base_q;
                  else if (sel < 30) r.query_address = limit[31:0] - 32'd1;
                  else if (sel < 40) r.query_address = limit[31:0];
                  else if (sel < 50) r.query_address = '0;
                  else if (sel < 60) r.query_address = '1;
               end
               default: begin
               end
            endcase
            push_request(r.opcode, r.request_bytes, r.query_address);
            n++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty pool after reset
      @(negedge clock);
      push_request(OP_CHECK,   32'h0,         32'h0);
      push_request(OP_ALLOC,   32'h0,         32'h0);
      push_request(OP_RELEASE, 32'h0,         32'h0);
      push_request(OP_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // 16-page pool at 0x1000_0000
      set_pool(32'h1000_0000, 32'h0001_0000);
      @(negedge clock);
      push_request(OP_ALLOC,   32'h0,         32'h0);          // empty region
      push_request(OP_ALLOC,   32'h1,         32'h0);          // shares the start above
      push_request(OP_ALLOC,   32'h1000,      32'hFFFF_FFFF);
      push_request(OP_ALLOC,   32'h1001,      32'h0);
      push_request(OP_ALLOC,   32'hFFFF_FFFF, 32'h0);
      push_request(OP_ALLOC,   32'hFFFF_F001, 32'h0);
      push_request(OP_RELEASE, 32'hFFFF_FFFF, 32'h1000_1000);  // first match: empty region
      push_request(OP_RELEASE, 32'h0,         32'h1000_3000);
      push_request(OP_RELEASE, 32'h0,         32'h1000_3001);
      push_request(OP_RELEASE, 32'h0,         32'hFFFF_FFFF);
      push_request(OP_CHECK,   32'h0,         32'h0FFF_FFFF);
      push_request(OP_CHECK,   32'h0,         32'h1000_0000);
      push_request(OP_CHECK,   32'hFFFF_FFFF, 32'h1000_FFFF);
      push_request(OP_CHECK,   32'h0,         32'h1001_0000);
      push_request(OP_CHECK,   32'h0,         32'hFFFF_FFFF);
      push_request(OP_ALLOC,   32'hB000,      32'h0);          // ends on the limit
      push_request(OP_ALLOC,   32'hA000,      32'h0);          // ends one page below
      push_request(OP_RELEASE, 32'h0,         32'h1000_5000);

      queue_random_phase(215);
      set_pool(32'h1000_0000, 32'h0004_0000);
      queue_random_phase(215);
      set_pool(32'h1000_0000, 32'h0010_0000);
      queue_random_phase(215);
      set_pool(32'h0000_0000, 32'hFFFF_FFFF);
      queue_random_phase(215);
      set_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_random_phase(215);
      set_pool($urandom, $urandom);
      queue_random_phase(215);
      set_pool(32'h0000_0000, 32'h0000_0000);
      queue_random_phase(215);

      wait_idle();
      $display("Ran %0d requests: %0d regions placed, %0d out of range, %0d on a full table.",
               n_issued, n_placed, n_range, n_full);
      $display("Releases %0d found, %0d not found; %0d of %0d checked addresses inside.",
               n_freed, n_missing, n_inside, n_checked);
      if (mismatch_count == 0 && awaited_responses.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
